// ===== rtl/core/day_count_to_calendar_time_defines.svh =====
// Assertion macros for the day count to calendar time block.
`ifndef DAY_COUNT_TO_CALENDAR_TIME_DEFINES_SVH
`define DAY_COUNT_TO_CALENDAR_TIME_DEFINES_SVH
`ifndef SYNTHESIS
`define DCCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcct assertion failed");
`define DCCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcct assertion failed");
`else
`define DCCT_ASSERT_IMP(lbl, ante, cons)
`define DCCT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/dcct_pkg.sv =====
// Types, constants and helper functions shared by the calendar time pipeline.
package dcct_pkg;

    localparam logic [22:0] MS_RECIP       = 23'd4294967;
    localparam logic [32:0] MS_PER_SEC     = 33'd1000;
    localparam logic [6:0]  SEC_RECIP      = 7'd97;
    localparam logic [23:0] SECS_PER_DAY   = 24'd86400;
    localparam logic [16:0] EPOCH_DAYS     = 17'd5113;
    localparam logic [5:0]  HOUR_RECIP     = 6'd36;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [6:0]  MIN_RECIP      = 7'd68;
    localparam logic [11:0] SECS_PER_MIN   = 12'd60;
    localparam logic [19:0] CIVIL_SHIFT    = 20'd719468;
    localparam logic [19:0] ERA4_START     = 20'd584388;
    localparam logic [19:0] ERA5_START     = 20'd730485;
    localparam logic [7:0]  Q4Y_RECIP      = 8'd179;
    localparam logic [17:0] DAYS_PER_4Y    = 18'd1460;
    localparam logic [17:0] DAYS_PER_100Y  = 18'd36524;
    localparam logic [17:0] DAYS_PER_400YM = 18'd146096;
    localparam logic [9:0]  YEAR_RECIP     = 10'd718;
    localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
    localparam logic [11:0] ERA4_YEAR      = 12'd1600;
    localparam logic [11:0] ERA5_YEAR      = 12'd2000;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millisecond;
    } tod_t;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } date_t;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd366;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/dcct_secs.sv =====
// Splits millis into seconds and milliseconds, then seconds into days and second of day.
module dcct_secs
    import dcct_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] day_count,
    input  logic [31:0] millis,
    output logic [16:0] dnum,
    output logic [16:0] sod,
    output logic [9:0]  ms
);

    logic [54:0] p1_reg;
    logic [31:0] millis1_reg;
    logic [15:0] day1_reg;

    logic [22:0] secs2_reg, secs2_next;
    logic [9:0]  ms2_reg, ms2_next;
    logic [15:0] day2_reg;

    logic [29:0] p2_reg;
    logic [22:0] secs3_reg;
    logic [9:0]  ms3_reg;
    logic [15:0] day3_reg;

    logic [16:0] sod4_reg, sod4_next;
    logic [16:0] dnum4_reg, dnum4_next;
    logic [9:0]  ms4_reg;

    logic [22:0] q1;
    logic [32:0] r1;
    logic [6:0]  q2, q2c;
    logic [23:0] r2;

    always_comb
    begin
        q1 = p1_reg[54:32];
        r1 = {1'b0, millis1_reg} - ({10'd0, q1} * MS_PER_SEC);
        if (r1 >= MS_PER_SEC)
        begin
            secs2_next = q1 + 23'd1;
            ms2_next   = 10'(r1 - MS_PER_SEC);
        end
        else
        begin
            secs2_next = q1;
            ms2_next   = r1[9:0];
        end
    end

    always_comb
    begin
        q2 = p2_reg[29:23];
        r2 = {1'b0, secs3_reg} - ({17'd0, q2} * SECS_PER_DAY);
        if (r2 >= SECS_PER_DAY)
        begin
            sod4_next = 17'(r2 - SECS_PER_DAY);
            q2c       = q2 + 7'd1;
        end
        else
        begin
            sod4_next = r2[16:0];
            q2c       = q2;
        end
        dnum4_next = {1'b0, day3_reg} + EPOCH_DAYS + {10'd0, q2c};
    end

    always_ff @(posedge clk)
    begin
        p1_reg      <= {23'd0, millis} * {32'd0, MS_RECIP};
        millis1_reg <= millis;
        day1_reg    <= day_count;

        secs2_reg   <= secs2_next;
        ms2_reg     <= ms2_next;
        day2_reg    <= day1_reg;

        p2_reg      <= {7'd0, secs2_reg} * {23'd0, SEC_RECIP};
        secs3_reg   <= secs2_reg;
        ms3_reg     <= ms2_reg;
        day3_reg    <= day2_reg;

        sod4_reg    <= sod4_next;
        dnum4_reg   <= dnum4_next;
        ms4_reg     <= ms3_reg;
    end

    assign dnum = dnum4_reg;
    assign sod  = sod4_reg;
    assign ms   = ms4_reg;

endmodule

// ===== rtl/core/dcct_tod.sv =====
// Splits the second of day into hour, minute and second over four stages.
module dcct_tod
    import dcct_pkg::*;
(
    input  logic        clk,
    input  logic [16:0] sod,
    input  logic [9:0]  ms,
    output tod_t        tod
);

    logic [22:0] p3_reg;
    logic [16:0] sod5_reg;
    logic [9:0]  ms5_reg;

    logic [4:0]  hour6_reg, hour6_next;
    logic [11:0] rem6_reg, rem6_next;
    logic [9:0]  ms6_reg;

    logic [18:0] p4_reg;
    logic [4:0]  hour7_reg;
    logic [11:0] rem7_reg;
    logic [9:0]  ms7_reg;

    tod_t        tod8_reg, tod8_next;

    logic [4:0]  q3;
    logic [16:0] r3;
    logic [5:0]  q4;
    logic [11:0] r4;

    always_comb
    begin
        q3 = p3_reg[21:17];
        r3 = sod5_reg - ({12'd0, q3} * SECS_PER_HOUR);
        if (r3 >= SECS_PER_HOUR)
        begin
            hour6_next = q3 + 5'd1;
            rem6_next  = 12'(r3 - SECS_PER_HOUR);
        end
        else
        begin
            hour6_next = q3;
            rem6_next  = r3[11:0];
        end
    end

    always_comb
    begin
        q4 = p4_reg[17:12];
        r4 = rem7_reg - ({6'd0, q4} * SECS_PER_MIN);
        tod8_next.hour        = hour7_reg;
        tod8_next.millisecond = ms7_reg;
        if (r4 >= SECS_PER_MIN)
        begin
            tod8_next.minute = q4 + 6'd1;
            tod8_next.second = 6'(r4 - SECS_PER_MIN);
        end
        else
        begin
            tod8_next.minute = q4;
            tod8_next.second = r4[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        p3_reg    <= {6'd0, sod} * {17'd0, HOUR_RECIP};
        sod5_reg  <= sod;
        ms5_reg   <= ms;

        hour6_reg <= hour6_next;
        rem6_reg  <= rem6_next;
        ms6_reg   <= ms5_reg;

        p4_reg    <= {7'd0, rem6_reg} * {12'd0, MIN_RECIP};
        hour7_reg <= hour6_reg;
        rem7_reg  <= rem6_reg;
        ms7_reg   <= ms6_reg;

        tod8_reg  <= tod8_next;
    end

    assign tod = tod8_reg;

endmodule

// ===== rtl/core/dcct_date.sv =====
// Converts a day number since 1970 into a Gregorian date over seven stages.
module dcct_date
    import dcct_pkg::*;
(
    input  logic        clk,
    input  logic [16:0] dnum,
    output date_t       date
);

    logic [17:0] doe5_reg, doe5_next;
    logic        era5_reg, era5_next;

    logic [25:0] p5_reg;
    logic [17:0] doe6_reg;
    logic        era6_reg;

    logic [17:0] num7_reg, num7_next;
    logic [17:0] doe7_reg;
    logic        era7_reg;

    logic [27:0] p6_reg;
    logic [17:0] num8_reg;
    logic [17:0] doe8_reg;
    logic        era8_reg;

    logic [8:0]  yoe9_reg, yoe9_next;
    logic [17:0] doe9_reg;
    logic        era9_reg;

    logic [8:0]  doy10_reg, doy10_next;
    logic [8:0]  yoe10_reg;
    logic        era10_reg;

    date_t       date11_reg, date11_next;

    logic [19:0] z;
    logic [19:0] doe_wide;
    logic [7:0]  q5, c1460;
    logic [17:0] r5;
    logic [2:0]  c36524;
    logic        c146096;
    logic [9:0]  q6;
    logic [17:0] r6;
    logic [1:0]  c100;
    logic [17:0] yr_days;
    logic [17:0] doy_wide;
    logic [3:0]  mp;
    logic [8:0]  dom_wide;
    logic [11:0] base_year;

    always_comb
    begin
        z         = {3'd0, dnum} + CIVIL_SHIFT;
        era5_next = (z >= ERA5_START);
        doe_wide  = era5_next ? (z - ERA5_START) : (z - ERA4_START);
        doe5_next = doe_wide[17:0];
    end

    always_comb
    begin
        q5 = p5_reg[25:18];
        r5 = doe6_reg - ({10'd0, q5} * DAYS_PER_4Y);
        c1460 = (r5 >= DAYS_PER_4Y) ? (q5 + 8'd1) : q5;
        c36524 = 3'(doe6_reg >= DAYS_PER_100Y)
               + 3'(doe6_reg >= 18'(2 * 36524))
               + 3'(doe6_reg >= 18'(3 * 36524))
               + 3'(doe6_reg >= 18'(4 * 36524));
        c146096 = (doe6_reg == DAYS_PER_400YM);
        num7_next = doe6_reg + {15'd0, c36524} - {10'd0, c1460} - {17'd0, c146096};
    end

    always_comb
    begin
        q6 = p6_reg[27:18];
        r6 = num8_reg - ({8'd0, q6} * DAYS_PER_YEAR);
        yoe9_next = (r6 >= DAYS_PER_YEAR) ? 9'(q6 + 10'd1) : q6[8:0];
    end

    always_comb
    begin
        c100 = 2'(yoe9_reg >= 9'd100) + 2'(yoe9_reg >= 9'd200) + 2'(yoe9_reg >= 9'd300);
        yr_days = ({9'd0, yoe9_reg} * DAYS_PER_YEAR) + {11'd0, yoe9_reg[8:2]}
                - {16'd0, c100};
        doy_wide = doe9_reg - yr_days;
        doy10_next = doy_wide[8:0];
    end

    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy10_reg >= month_start(4'(i)))
            begin
                mp = mp + 4'd1;
            end
        end
        dom_wide = doy10_reg - month_start(mp) + 9'd1;
        date11_next.day_of_month = dom_wide[4:0];
        date11_next.month = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
        base_year = era10_reg ? ERA5_YEAR : ERA4_YEAR;
        date11_next.year = base_year + {3'd0, yoe10_reg}
                         + {11'd0, (date11_next.month <= 4'd2)};
    end

    always_ff @(posedge clk)
    begin
        doe5_reg   <= doe5_next;
        era5_reg   <= era5_next;

        p5_reg     <= {8'd0, doe5_reg} * {18'd0, Q4Y_RECIP};
        doe6_reg   <= doe5_reg;
        era6_reg   <= era5_reg;

        num7_reg   <= num7_next;
        doe7_reg   <= doe6_reg;
        era7_reg   <= era6_reg;

        p6_reg     <= {10'd0, num7_reg} * {18'd0, YEAR_RECIP};
        num8_reg   <= num7_reg;
        doe8_reg   <= doe7_reg;
        era8_reg   <= era7_reg;

        yoe9_reg   <= yoe9_next;
        doe9_reg   <= doe8_reg;
        era9_reg   <= era8_reg;

        doy10_reg  <= doy10_next;
        yoe10_reg  <= yoe9_reg;
        era10_reg  <= era9_reg;

        date11_reg <= date11_next;
    end

    assign date = date11_reg;

endmodule

// ===== rtl/core/day_count_to_calendar_time.sv =====
// Day count and millisecond timestamp to UTC calendar date and time of day.
// A request accepted at a clock edge shows on the result ports, with done high,
// after passing eleven register stages set by the constant dividers.
// Throughput: one request per cycle; busy is never raised.
// Reset clears only the valid pipeline; requests in flight are dropped.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "day_count_to_calendar_time_defines.svh"
module day_count_to_calendar_time
    import dcct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] day_count,
    input  logic [31:0] millis,
    output logic        done,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month,
    output logic [11:0] year,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [9:0]  millisecond
);

    logic [10:0] valid_reg, valid_next;
    tod_t        tod_dly_reg [3];

    logic [16:0] dnum;
    logic [16:0] sod;
    logic [9:0]  ms;
    tod_t        tod;
    date_t       date;

    logic        date_ok;
    logic        time_ok;

    dcct_secs u_secs
    (
        .clk       (clk),
        .day_count (day_count),
        .millis    (millis),
        .dnum      (dnum),
        .sod       (sod),
        .ms        (ms)
    );

    dcct_tod u_tod
    (
        .clk (clk),
        .sod (sod),
        .ms  (ms),
        .tod (tod)
    );

    dcct_date u_date
    (
        .clk  (clk),
        .dnum (dnum),
        .date (date)
    );

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[9:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the time of day until the date catches up
    always_ff @(posedge clk)
    begin
        tod_dly_reg[0] <= tod;
        tod_dly_reg[1] <= tod_dly_reg[0];
        tod_dly_reg[2] <= tod_dly_reg[1];
    end

    assign done         = valid_reg[10];
    assign day_of_month = date.day_of_month;
    assign month        = date.month;
    assign year         = date.year;
    assign hour         = tod_dly_reg[2].hour;
    assign minute       = tod_dly_reg[2].minute;
    assign second       = tod_dly_reg[2].second;
    assign millisecond  = tod_dly_reg[2].millisecond;

    assign date_ok = (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0)
                     && (year >= 12'd1984) && (year <= 12'd2299);
    assign time_ok = (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
                     && (millisecond <= 10'd999);

    `DCCT_ASSERT_IMP(a_done_follows_request, done, $past(start, 11))
    `DCCT_ASSERT_NEXT(a_request_gives_result, valid_reg[9], done)
    `DCCT_ASSERT_IMP(a_date_range, done, date_ok)
    `DCCT_ASSERT_IMP(a_time_range, done, time_ok)

endmodule
